// ----- hw/rtl/sem_pkg.sv -----
// Shared types and constants for the Sobel edge magnitude block.
// No dependencies; all other files but sem_ram refer to it by scoped names.

package sem_pkg;

  localparam int PIX_W        = 8;
  localparam int CFG_W        = 14;
  localparam int ROW_W        = 13;
  localparam int MAX_HEIGHT   = 8192;
  localparam int MAX_WIDTH_DEF = 8192;
  localparam int MIN_DIM      = 3;
  localparam int WIDTH_RESET  = 1024;
  localparam int HEIGHT_RESET = 768;
  localparam int QUEUE_DEPTH  = 4;
  localparam int LVL_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int APB_AW       = 3;
  localparam int APB_DW       = 32;

  // Register index codes, decoded from paddr[2].
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [CFG_W-1:0] width;
    logic [CFG_W-1:0] height;
    logic             restart;
  } frame_cfg_t;

  // One new window column plus the output classification of its pixel.
  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
    logic             produce;
    logic             row_end;
    logic             frame_end;
  } col_entry_t;

  localparam int ENTRY_W = $bits(col_entry_t);

endpackage

// ----- hw/rtl/sem_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.

module sem_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/sem_front.sv -----
// Front end: pixel intake, intensity, raster counters, line buffer access.
// Depends on sem_pkg and sem_ram; pushes one window column per pixel into the queue.

module sem_front #(
  parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sem_pkg::frame_cfg_t         cfg,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [sem_pkg::PIX_W-1:0]   in_blue,
  input  logic [sem_pkg::PIX_W-1:0]   in_green,
  input  logic [sem_pkg::PIX_W-1:0]   in_red,
  input  logic [sem_pkg::LVL_W-1:0]   q_level,
  output logic                        q_push,
  output sem_pkg::col_entry_t         q_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int EW = sem_pkg::CFG_W + 1;
  localparam int HW = sem_pkg::CFG_W;
  localparam logic [EW-1:0] MAXW = EW'(MAX_WIDTH);
  localparam logic [HW-1:0] MAXH = HW'(sem_pkg::MAX_HEIGHT);
  localparam logic [EW-1:0] MINW = EW'(sem_pkg::MIN_DIM);
  localparam logic [HW-1:0] MINH = HW'(sem_pkg::MIN_DIM);
  localparam logic [19:0]   DIV3_RECIP = 20'd683;

  logic [CW-1:0]                  col_r;
  logic [sem_pkg::ROW_W-1:0]      row_r;
  logic                           f1_valid_r;
  logic [CW-1:0]                  f1_col_r;
  logic [sem_pkg::PIX_W-1:0]      f1_int_r;
  logic                           f1_produce_r;
  logic                           f1_row_end_r;
  logic                           f1_frame_end_r;

  logic [EW-1:0]                  raw_w;
  logic [EW-1:0]                  eff_w;
  logic [HW-1:0]                  eff_h;
  logic                           accept;
  logic                           last_col;
  logic                           last_row;
  logic [9:0]                     chan_sum;
  logic [19:0]                    div_prod;
  logic [sem_pkg::PIX_W-1:0]      intensity;
  logic [2*sem_pkg::PIX_W-1:0]    rd_data;

  always_comb begin
    raw_w = EW'(cfg.width);
    if (raw_w < MINW) begin
      eff_w = MINW;
    end else if (raw_w > MAXW) begin
      eff_w = MAXW;
    end else begin
      eff_w = raw_w;
    end
    if (cfg.height < MINH) begin
      eff_h = MINH;
    end else if (cfg.height > MAXH) begin
      eff_h = MAXH;
    end else begin
      eff_h = cfg.height;
    end
  end

  // One slot is held back for the pixel that is still reading the line buffer.
  assign in_stall = ({1'b0, q_level} + {{sem_pkg::LVL_W{1'b0}}, f1_valid_r})
                    >= (sem_pkg::LVL_W + 1)'(sem_pkg::QUEUE_DEPTH);
  assign accept   = in_valid && !in_stall;

  assign last_col = (EW'(col_r) + EW'(1)) == eff_w;
  assign last_row = (HW'(row_r) + HW'(1)) == eff_h;

  // The sum is at most 765, where multiplying by 683/2048 floors exactly to sum/3.
  assign chan_sum  = 10'(in_blue) + 10'(in_green) + 10'(in_red);
  assign div_prod  = 20'(chan_sum) * DIV3_RECIP;
  assign intensity = div_prod[18:11];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      f1_valid_r <= 1'b0;
    end else begin
      f1_valid_r <= accept;
      if (cfg.restart) begin
        col_r <= '0;
        row_r <= '0;
      end else if (accept) begin
        if (last_col) begin
          col_r <= '0;
          row_r <= last_row ? '0 : row_r + 1'b1;
        end else begin
          col_r <= col_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_col_r       <= col_r;
      f1_int_r       <= intensity;
      f1_produce_r   <= (row_r >= sem_pkg::ROW_W'(2)) && (col_r >= CW'(2));
      f1_row_end_r   <= last_col;
      f1_frame_end_r <= last_col && last_row;
    end
  end

  // Each entry holds {row r-2, row r-1} for its column.
  sem_ram #(
    .WIDTH(2 * sem_pkg::PIX_W),
    .DEPTH(MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (f1_valid_r),
    .waddr (f1_col_r),
    .wdata ({rd_data[sem_pkg::PIX_W-1:0], f1_int_r}),
    .re    (accept),
    .raddr (col_r),
    .rdata (rd_data)
  );

  assign q_push = f1_valid_r;

  always_comb begin
    q_data.top       = rd_data[2*sem_pkg::PIX_W-1:sem_pkg::PIX_W];
    q_data.mid       = rd_data[sem_pkg::PIX_W-1:0];
    q_data.bot       = f1_int_r;
    q_data.produce   = f1_produce_r;
    q_data.row_end   = f1_row_end_r;
    q_data.frame_end = f1_frame_end_r;
  end

endmodule

// ----- hw/rtl/sem_queue.sv -----
// Short register queue of window columns between the front and back ends.
// Depends on sem_pkg.

module sem_queue (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  sem_pkg::col_entry_t       push_data,
  input  logic                      pop,
  output sem_pkg::col_entry_t       pop_data,
  output logic                      empty,
  output logic [sem_pkg::LVL_W-1:0] level
);

  localparam int PW = $clog2(sem_pkg::QUEUE_DEPTH);

  sem_pkg::col_entry_t        slot_r [sem_pkg::QUEUE_DEPTH];
  logic [PW-1:0]              wr_ptr_r;
  logic [PW-1:0]              rd_ptr_r;
  logic [sem_pkg::LVL_W-1:0]  level_r;

  assign empty    = (level_r == '0);
  assign level    = level_r;
  assign pop_data = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        level_r <= level_r + 1'b1;
      end else if (pop && !push) begin
        level_r <= level_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- hw/rtl/sem_back.sv -----
// Back end: 3x3 window, Sobel sums, squares, two-stage integer square root.
// Depends on sem_pkg; drains the column queue and drives the result channel.

module sem_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  sem_pkg::col_entry_t       q_data,
  input  logic                      q_empty,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [sem_pkg::PIX_W-1:0] out_magnitude,
  output logic                      out_row_end,
  output logic                      out_frame_end
);

  localparam int PW = sem_pkg::PIX_W;
  localparam int GW = PW + 3;
  localparam int SW = 2 * PW;

  typedef struct packed {
    logic [SW-1:0]  val;
    logic [GW-1:0]  rem;
    logic [PW-1:0]  root;
  } isqrt_t;

  // One digit of the restoring square root: two radicand bits in, one root bit out.
  function automatic isqrt_t isqrt_step(isqrt_t s);
    isqrt_t        n;
    logic [GW-1:0] rem_sh;
    logic [GW-1:0] trial;
    rem_sh = {s.rem[PW:0], s.val[SW-1:SW-2]};
    trial  = {1'b0, s.root, 2'b01};
    n.val  = {s.val[SW-3:0], 2'b00};
    if (rem_sh >= trial) begin
      n.rem  = rem_sh - trial;
      n.root = {s.root[PW-2:0], 1'b1};
    end else begin
      n.rem  = rem_sh;
      n.root = {s.root[PW-2:0], 1'b0};
    end
    return n;
  endfunction

  function automatic logic [PW-1:0] abs_clamp(logic signed [GW-1:0] v);
    logic [GW-1:0] a;
    a = v[GW-1] ? GW'(-v) : GW'(v);
    return (a > GW'(8'hFF)) ? 8'hFF : a[PW-1:0];
  endfunction

  logic                    adv;
  logic [PW-1:0]           col0_r [3];
  logic [PW-1:0]           col1_r [3];
  logic [PW-1:0]           col2   [3];

  logic                    b1_valid_r;
  logic signed [GW-1:0]    gx_r;
  logic signed [GW-1:0]    gy_r;
  logic                    b1_row_end_r;
  logic                    b1_frame_end_r;

  logic                    b2_valid_r;
  logic [SW-1:0]           sqx_r;
  logic [SW-1:0]           sqy_r;
  logic                    b2_row_end_r;
  logic                    b2_frame_end_r;

  logic                    b3_valid_r;
  isqrt_t                  b3_sq_r;
  logic                    b3_sat_r;
  logic                    b3_row_end_r;
  logic                    b3_frame_end_r;

  logic                    out_valid_r;
  logic [PW-1:0]           out_mag_r;
  logic                    out_row_end_r;
  logic                    out_frame_end_r;

  logic [GW-1:0]           sum_right;
  logic [GW-1:0]           sum_left;
  logic [GW-1:0]           sum_bottom;
  logic [GW-1:0]           sum_top;
  logic [PW-1:0]           ax;
  logic [PW-1:0]           ay;
  logic [SW:0]             sq_sum;
  isqrt_t                  s3_chain [5];
  isqrt_t                  s4_chain [5];

  // The whole back pipeline moves together whenever the result register can move.
  assign adv   = !out_valid_r || !out_stall;
  assign q_pop = adv && !q_empty;

  assign col2[0] = q_data.top;
  assign col2[1] = q_data.mid;
  assign col2[2] = q_data.bot;

  always_comb begin
    sum_right  = GW'(col2[0]) + {2'b00, col2[1], 1'b0} + GW'(col2[2]);
    sum_left   = GW'(col0_r[0]) + {2'b00, col0_r[1], 1'b0} + GW'(col0_r[2]);
    sum_bottom = GW'(col0_r[2]) + {2'b00, col1_r[2], 1'b0} + GW'(col2[2]);
    sum_top    = GW'(col0_r[0]) + {2'b00, col1_r[0], 1'b0} + GW'(col2[0]);
  end

  assign ax     = abs_clamp(gx_r);
  assign ay     = abs_clamp(gy_r);
  assign sq_sum = {1'b0, sqx_r} + {1'b0, sqy_r};

  always_comb begin
    s3_chain[0].val  = sq_sum[SW-1:0];
    s3_chain[0].rem  = '0;
    s3_chain[0].root = '0;
    for (int i = 0; i < 4; i++) begin
      s3_chain[i+1] = isqrt_step(s3_chain[i]);
    end
    s4_chain[0] = b3_sq_r;
    for (int i = 0; i < 4; i++) begin
      s4_chain[i+1] = isqrt_step(s4_chain[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_valid_r  <= 1'b0;
      b2_valid_r  <= 1'b0;
      b3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      b1_valid_r  <= q_pop && q_data.produce;
      b2_valid_r  <= b1_valid_r;
      b3_valid_r  <= b2_valid_r;
      out_valid_r <= b3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      for (int i = 0; i < 3; i++) begin
        col0_r[i] <= col1_r[i];
        col1_r[i] <= col2[i];
      end
    end
    if (adv) begin
      gx_r            <= $signed(sum_right) - $signed(sum_left);
      gy_r            <= $signed(sum_bottom) - $signed(sum_top);
      b1_row_end_r    <= q_data.row_end;
      b1_frame_end_r  <= q_data.frame_end;

      sqx_r           <= SW'(ax) * SW'(ax);
      sqy_r           <= SW'(ay) * SW'(ay);
      b2_row_end_r    <= b1_row_end_r;
      b2_frame_end_r  <= b1_frame_end_r;

      // A sum of 65536 or more has a root above 255 and saturates.
      b3_sq_r         <= s3_chain[4];
      b3_sat_r        <= sq_sum[SW];
      b3_row_end_r    <= b2_row_end_r;
      b3_frame_end_r  <= b2_frame_end_r;

      out_mag_r       <= b3_sat_r ? {PW{1'b1}} : s4_chain[4].root;
      out_row_end_r   <= b3_row_end_r;
      out_frame_end_r <= b3_frame_end_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_magnitude = out_mag_r;
  assign out_row_end   = out_row_end_r;
  assign out_frame_end = out_frame_end_r;

endmodule

// ----- hw/rtl/sobel_edge_magnitude.sv -----
// Sobel edge magnitude: top level with the register file and the pipeline halves.
// Depends on sem_pkg, sem_front, sem_queue and sem_back.
//
// Usage: RGB pixels enter in raster order on the in_ channel; each is accepted at a
// clock edge with in_valid high and in_stall low. Every pixel whose 3x3 window lies
// inside the frame (row >= 2 and column >= 2) yields one result on the out_ channel,
// taken at an edge with out_valid high and out_stall low. row_end and frame_end mark
// the last result of an output row and of the frame; the frame then restarts.
// The block sustains one pixel per clock while out_stall is low. Each pixel passes
// through the line buffer read and the column queue, then four stages for the
// gradient, the squares and the two halves of the square root.
// When out_stall is high while out_valid is set, the result register holds and the
// back stages freeze; the front keeps taking pixels until the four-entry column
// queue fills, then raises in_stall.
// Reset clears the counters and the pipeline and sets the width to 1024 and the
// height to 768. No line buffer clearing pass is needed, since stale entries never
// reach a result. Writing either register through the APB port restarts the frame.

module sobel_edge_magnitude #(
  parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [sem_pkg::PIX_W-1:0]   in_blue,
  input  logic [sem_pkg::PIX_W-1:0]   in_green,
  input  logic [sem_pkg::PIX_W-1:0]   in_red,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [sem_pkg::PIX_W-1:0]   out_magnitude,
  output logic                        out_row_end,
  output logic                        out_frame_end,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sem_pkg::APB_AW-1:0]  paddr,
  input  logic [sem_pkg::APB_DW-1:0]  pwdata,
  output logic [sem_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  logic [sem_pkg::CFG_W-1:0]  width_r;
  logic [sem_pkg::CFG_W-1:0]  height_r;
  logic                       wr_en;
  logic                       reg_sel;
  sem_pkg::frame_cfg_t        cfg;
  logic                       q_push;
  logic                       q_pop;
  logic                       q_empty;
  logic [sem_pkg::LVL_W-1:0]  q_level;
  sem_pkg::col_entry_t        q_in;
  sem_pkg::col_entry_t        q_out;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= sem_pkg::CFG_W'(sem_pkg::WIDTH_RESET);
      height_r <= sem_pkg::CFG_W'(sem_pkg::HEIGHT_RESET);
    end else if (wr_en) begin
      if (reg_sel == sem_pkg::REG_WIDTH) begin
        width_r <= pwdata[sem_pkg::CFG_W-1:0];
      end else begin
        height_r <= pwdata[sem_pkg::CFG_W-1:0];
      end
    end
  end

  always_comb begin
    case (reg_sel)
      sem_pkg::REG_WIDTH:  prdata = sem_pkg::APB_DW'(width_r);
      sem_pkg::REG_HEIGHT: prdata = sem_pkg::APB_DW'(height_r);
      default:             prdata = '0;
    endcase
  end

  always_comb begin
    cfg.width   = width_r;
    cfg.height  = height_r;
    cfg.restart = wr_en;
  end

  sem_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_blue  (in_blue),
    .in_green (in_green),
    .in_red   (in_red),
    .q_level  (q_level),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  sem_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty),
    .level     (q_level)
  );

  sem_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_data        (q_out),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_magnitude (out_magnitude),
    .out_row_end   (out_row_end),
    .out_frame_end (out_frame_end)
  );

endmodule

// ----- hw/rtl/sem_checker.sv -----
// Port-level checks for the Sobel edge magnitude block, bound to the top level.
// Depends on sem_pkg.

module sem_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [sem_pkg::PIX_W-1:0]   in_blue,
  input  logic [sem_pkg::PIX_W-1:0]   in_green,
  input  logic [sem_pkg::PIX_W-1:0]   in_red,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [sem_pkg::PIX_W-1:0]   out_magnitude,
  input  logic                        out_row_end,
  input  logic                        out_frame_end,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sem_pkg::APB_AW-1:0]  paddr,
  input  logic [sem_pkg::APB_DW-1:0]  pwdata,
  input  logic [sem_pkg::APB_DW-1:0]  prdata,
  input  logic                        pready
);

  // A stalled request holds its pixel until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_blue) && $stable(in_green)
      && $stable(in_red))
    else $error("stalled request changed");

  // A stalled result holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_magnitude)
      && $stable(out_row_end) && $stable(out_frame_end))
    else $error("stalled result changed");

  // The last pixel of a frame is also the last of its row.
  a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> out_row_end)
    else $error("frame end without row end");

  // Reset empties the pipeline and the queue.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

  // A register reads back what was just written to it.
  a_readback: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(psel && penable && pwrite && pready) && psel && !pwrite
      && paddr[2] == $past(paddr[2])
      |-> prdata[sem_pkg::CFG_W-1:0] == $past(pwdata[sem_pkg::CFG_W-1:0]))
    else $error("register readback mismatch");

endmodule

bind sobel_edge_magnitude sem_checker u_sem_checker (.*);

// ----- bench/tb.sv -----
// Testbench for sobel_edge_magnitude: streams RGB pixel requests through the block
// and checks every gradient result against a predictor kept in the bench.
// Depends on sem_pkg and the sobel_edge_magnitude RTL.

module tb;

  localparam int PIX_W       = sem_pkg::PIX_W;
  localparam int CFG_W       = sem_pkg::CFG_W;
  localparam int APB_AW      = sem_pkg::APB_AW;
  localparam int APB_DW      = sem_pkg::APB_DW;
  localparam int MIN_DIM     = sem_pkg::MIN_DIM;
  localparam int MAX_HEIGHT  = sem_pkg::MAX_HEIGHT;
  localparam int MAX_W       = sem_pkg::MAX_WIDTH_DEF;
  localparam int PIX_MAX     = 255;
  localparam int SETTLE      = 20;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_PCT    = 22;

  typedef enum {PAT_NOISE, PAT_SMOOTH, PAT_FLAT} pattern_t;

  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
  } rgb_t;

  typedef struct packed {
    logic [PIX_W-1:0] magnitude;
    logic             row_end;
    logic             frame_end;
  } grad_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [PIX_W-1:0]  in_blue = '0;
  logic [PIX_W-1:0]  in_green = '0;
  logic [PIX_W-1:0]  in_red = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [PIX_W-1:0]  out_magnitude;
  logic              out_row_end;
  logic              out_frame_end;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  // Predicted state of the block.
  logic [PIX_W-1:0] row_last [MAX_W];
  logic [PIX_W-1:0] row_older [MAX_W];
  logic [PIX_W-1:0] col_far [3];
  logic [PIX_W-1:0] col_near [3];
  int               col_pos;
  int               row_pos;
  logic [CFG_W-1:0] width_reg = CFG_W'(sem_pkg::WIDTH_RESET);
  logic [CFG_W-1:0] height_reg = CFG_W'(sem_pkg::HEIGHT_RESET);

  rgb_t  pixels_pending [$];
  grad_t grads_due [$];
  int    errors = 0;
  int    quiet = 0;
  int    hold_asks = 0;
  int    hold_served = 0;
  int    hold_left = 0;
  logic  calm = 1'b0;

  sobel_edge_magnitude i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_blue       (in_blue),
    .in_green      (in_green),
    .in_red        (in_red),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_magnitude (out_magnitude),
    .out_row_end   (out_row_end),
    .out_frame_end (out_frame_end),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int clip_dim(input int v, input int hi);
    if (v < MIN_DIM) return MIN_DIM;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int root_floor(input int v);
    int r;
    int b;
    r = 0;
    for (b = 512; b != 0; b = b >> 1) begin
      if ((r + b) * (r + b) <= v) r = r + b;
    end
    return r;
  endfunction

  // Advances the predicted pipeline by one pixel and queues the result it closes.
  function automatic void track_pixel(input rgb_t px);
    int    w, h, c, r, gx, gy, ax, ay, mag, a;
    int    p [3][3];
    logic [PIX_W-1:0] lum, top, mid;
    grad_t g;
    w = clip_dim(int'(width_reg), MAX_W);
    h = clip_dim(int'(height_reg), MAX_HEIGHT);
    if (col_pos >= w) col_pos = 0;
    if (row_pos >= h) row_pos = 0;
    c = col_pos;
    r = row_pos;
    lum = PIX_W'((int'(px.blue) + int'(px.green) + int'(px.red)) / 3);
    top = row_older[c];
    mid = row_last[c];
    row_older[c] = mid;
    row_last[c] = lum;
    for (a = 0; a < 3; a++) begin
      p[a][0] = int'(col_far[a]);
      p[a][1] = int'(col_near[a]);
    end
    p[0][2] = int'(top);
    p[1][2] = int'(mid);
    p[2][2] = int'(lum);
    if (r >= 2 && c >= 2) begin
      gx = p[0][2] - p[0][0] + 2 * (p[1][2] - p[1][0]) + p[2][2] - p[2][0];
      gy = p[2][0] + 2 * p[2][1] + p[2][2] - p[0][0] - 2 * p[0][1] - p[0][2];
      ax = gx < 0 ? -gx : gx;
      ay = gy < 0 ? -gy : gy;
      if (ax > PIX_MAX) ax = PIX_MAX;
      if (ay > PIX_MAX) ay = PIX_MAX;
      mag = root_floor(ax * ax + ay * ay);
      if (mag > PIX_MAX) mag = PIX_MAX;
      g.magnitude = PIX_W'(mag);
      g.row_end = (c == w - 1);
      g.frame_end = (c == w - 1) && (r == h - 1);
      grads_due.push_back(g);
    end
    for (a = 0; a < 3; a++) begin
      col_far[a] = PIX_W'(p[a][1]);
      col_near[a] = PIX_W'(p[a][2]);
    end
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endfunction

  // Pixel driver: a request stays on the port until the block takes it.
  always @(posedge clk) begin : feed
    rgb_t px;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) track_pixel({in_blue, in_green, in_red});
      if (!in_valid || !in_stall) begin
        if (pixels_pending.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          px = pixels_pending.pop_front();
          in_blue <= px.blue;
          in_green <= px.green;
          in_red <= px.red;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver back-pressure.
  always @(posedge clk) begin : watch
    grad_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (grads_due.size() == 0) begin
          $display("%0t: result with none expected: magnitude %0d row_end %0b frame_end %0b",
                   $time, out_magnitude, out_row_end, out_frame_end);
          errors++;
        end else begin
          want = grads_due.pop_front();
          if (out_magnitude !== want.magnitude) begin
            $display("%0t: magnitude expected %0d actual %0d",
                     $time, want.magnitude, out_magnitude);
            errors++;
          end
          if (out_row_end !== want.row_end) begin
            $display("%0t: row_end expected %0b actual %0b", $time, want.row_end, out_row_end);
            errors++;
          end
          if (out_frame_end !== want.frame_end) begin
            $display("%0t: frame_end expected %0b actual %0b",
                     $time, want.frame_end, out_frame_end);
            errors++;
          end
        end
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (hold_served != hold_asks) begin
        out_stall <= 1'b1;
        hold_left <= HOLD_CYCLES;
        hold_served <= hold_served + 1;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("tb failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // One APB transfer; a write also restarts the predicted frame, a read is checked.
  task automatic reg_access(input logic wr, input logic idx, input logic [CFG_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= APB_DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (wr) begin
      if (idx == sem_pkg::REG_WIDTH) width_reg = value;
      else height_reg = value;
      col_pos = 0;
      row_pos = 0;
    end else if (prdata[CFG_W-1:0] !==
                 (idx == sem_pkg::REG_WIDTH ? width_reg : height_reg)) begin
      $display("%0t: register %0d read expected %0d actual %0d", $time, idx,
               (idx == sem_pkg::REG_WIDTH ? width_reg : height_reg), prdata[CFG_W-1:0]);
      errors++;
    end
  endtask

  task automatic set_frame(input int w, input int h);
    reg_access(1'b1, sem_pkg::REG_WIDTH, CFG_W'(w));
    reg_access(1'b1, sem_pkg::REG_HEIGHT, CFG_W'(h));
    reg_access(1'b0, sem_pkg::REG_WIDTH, '0);
    reg_access(1'b0, sem_pkg::REG_HEIGHT, '0);
  endtask

  task automatic add_pixels(input int n, input pattern_t mode);
    rgb_t flat, px;
    int   base, k;
    flat = rgb_t'(24'($urandom));
    base = $urandom_range(0, 243);
    for (k = 0; k < n; k++) begin
      case (mode)
        PAT_NOISE: px = rgb_t'(24'($urandom));
        PAT_SMOOTH: begin
          px.blue = PIX_W'(base + $urandom_range(0, 12));
          px.green = PIX_W'(base + $urandom_range(0, 12));
          px.red = PIX_W'(base + $urandom_range(0, 12));
        end
        default: px = ($urandom_range(0, 15) == 0) ? rgb_t'(24'($urandom)) : flat;
      endcase
      pixels_pending.push_back(px);
    end
  endtask

  // Waits until the block is idle; pixels that make no result may still be in flight.
  task automatic drain();
    while (pixels_pending.size() != 0 || in_valid || grads_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin : stimulus
    int       k, r, c, w, h, n, sel, random_items;
    rgb_t     black, white;
    pattern_t mode;
    black = '0;
    white = '1;
    for (k = 0; k < MAX_W; k++) begin
      row_last[k] = '0;
      row_older[k] = '0;
    end
    for (k = 0; k < 3; k++) begin
      col_far[k] = '0;
      col_near[k] = '0;
    end
    col_pos = 0;
    row_pos = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values, then a few pixels of the default frame, which yield nothing.
    reg_access(1'b0, sem_pkg::REG_WIDTH, '0);
    reg_access(1'b0, sem_pkg::REG_HEIGHT, '0);
    add_pixels(6, PAT_NOISE);
    drain();

    // Dimensions below the minimum saturate to a 3x3 frame: a dark-to-bright
    // vertical edge that clamps the horizontal sum.
    set_frame(0, 1);
    for (r = 0; r < 3; r++) begin
      for (c = 0; c < 3; c++) begin
        if (c == 0) pixels_pending.push_back(black);
        else if (c == 1) pixels_pending.push_back(rgb_t'{8'hAA, 8'h55, 8'h0F});
        else pixels_pending.push_back(white);
      end
    end
    drain();

    // Diagonal edge: both sums clamp and the root itself exceeds the clamp.
    // The corners also check that the channel average rounds down.
    set_frame(3, 3);
    for (r = 0; r < 3; r++) begin
      for (c = 0; c < 3; c++) begin
        if (r == 0 && c == 0) pixels_pending.push_back(rgb_t'{8'd0, 8'd0, 8'd2});
        else if (r == 2 && c == 2) pixels_pending.push_back(rgb_t'{8'd255, 8'd255, 8'd254});
        else if (r + c >= 2) pixels_pending.push_back(white);
        else pixels_pending.push_back(black);
      end
    end
    drain();

    // Largest register values saturate; these frames are far too big to finish.
    set_frame(16383, 16383);
    add_pixels(30, PAT_NOISE);
    drain();
    set_frame(MAX_W, MIN_DIM);
    add_pixels(30, PAT_NOISE);
    drain();
    set_frame(MIN_DIM, MAX_HEIGHT);
    add_pixels(90, PAT_SMOOTH);
    drain();

    // Back-pressure: the receiver holds off while the sender keeps pushing.
    set_frame(8, 40);
    calm <= 1'b1;
    hold_asks <= hold_asks + 1;
    add_pixels(320, PAT_SMOOTH);
    drain();
    calm <= 1'b0;

    random_items = 0;
    while (random_items < 760) begin
      sel = $urandom_range(0, 99);
      if (sel < 5) w = $urandom_range(0, 2);
      else if (sel < 12) w = $urandom_range(40, 70);
      else w = $urandom_range(3, 12);
      sel = $urandom_range(0, 99);
      if (sel < 5) h = $urandom_range(0, 2);
      else if (sel < 9) h = $urandom_range(MAX_HEIGHT + 1, 16383);
      else h = $urandom_range(3, 10);
      // Sometimes only the height is rewritten, which still restarts the frame.
      if ($urandom_range(0, 3) == 0) reg_access(1'b1, sem_pkg::REG_HEIGHT, CFG_W'(h));
      else set_frame(w, h);
      w = clip_dim(int'(width_reg), MAX_W);
      h = clip_dim(int'(height_reg), MAX_HEIGHT);
      n = w * $urandom_range(2, 3 * h + 2);
      if (n > 400) n = 400;
      sel = $urandom_range(0, 9);
      if (sel < 4) mode = PAT_NOISE;
      else if (sel < 9) mode = PAT_SMOOTH;
      else mode = PAT_FLAT;
      add_pixels(n, mode);
      random_items += n;
      drain();
    end

    if (errors == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule
